// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define ASSERT_ON(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Checked at every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

// ===== rtl/u8d_pkg.sv =====
// Types and constants shared by the UTF-8 stream decoder.
`timescale 1ns / 1ps

package u8d_pkg;

  localparam int unsigned CpW        = 21;
  localparam int unsigned CntW       = 3;
  localparam int unsigned QueueDepth = 2;

  localparam logic KindByte = 1'b0;
  localparam logic KindEnd  = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] text_byte;
  } in_t;

  typedef struct packed {
    logic [CpW-1:0]  code_point;
    logic            invalid;
    logic [CntW-1:0] byte_count;
    logic            last;
  } out_t;

  // One request's worth of results: a run of invalid bytes, then an optional tail.
  typedef struct packed {
    logic [1:0]      inv_cnt;
    logic            has_tail;
    logic [CpW-1:0]  tail_cp;
    logic            tail_inv;
    logic [CntW-1:0] tail_cnt;
  } job_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_status_t;

  typedef enum logic [2:0] {
    ClsAscii,
    ClsLead2,
    ClsLead3,
    ClsLead4,
    ClsCont,
    ClsBad
  } byte_class_e;

endpackage

// ===== rtl/u8d_front.sv =====
// Front end: accepts bytes, tracks the pending sequence and builds result jobs.
`timescale 1ns / 1ps

module u8d_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  u8d_pkg::in_t       in_data_i,
  input  u8d_pkg::q_status_t q_status_i,
  output logic               push_o,
  output u8d_pkg::job_t      job_o
);

  logic [u8d_pkg::CpW-1:0]  partial_q, partial_d;
  logic [u8d_pkg::CntW-1:0] seq_len_q, seq_len_d;
  logic [1:0]               taken_q, taken_d;
  logic [1:0]               taken_plus;
  logic                     complete;
  logic                     fresh_en;
  logic                     accept;
  logic [7:0]               b;
  u8d_pkg::byte_class_e     cls;
  u8d_pkg::job_t            job;

  function automatic u8d_pkg::byte_class_e classify(input logic [7:0] v);
    u8d_pkg::byte_class_e c;
    if (!v[7])                   c = u8d_pkg::ClsAscii;
    else if (v[7:6] == 2'b10)    c = u8d_pkg::ClsCont;
    else if (v[7:5] == 3'b110)   c = u8d_pkg::ClsLead2;
    else if (v[7:4] == 4'b1110)  c = u8d_pkg::ClsLead3;
    else if (v[7:3] == 5'b11110) c = u8d_pkg::ClsLead4;
    else                         c = u8d_pkg::ClsBad;
    return c;
  endfunction

  assign b          = in_data_i.text_byte;
  assign cls        = classify(b);
  assign in_ready_o = !q_status_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign taken_plus = taken_q + 2'd1;
  // A four-byte form wraps the two-bit count to zero on its last byte.
  assign complete   = ({1'b0, taken_plus} >= seq_len_q) || (taken_plus == 2'd0);

  always_comb begin
    job       = '0;
    partial_d = partial_q;
    seq_len_d = seq_len_q;
    taken_d   = taken_q;
    fresh_en  = 1'b0;

    if (in_data_i.kind == u8d_pkg::KindEnd) begin
      job.inv_cnt = taken_q;
      partial_d   = '0;
      seq_len_d   = '0;
      taken_d     = '0;
    end else if (seq_len_q == '0) begin
      fresh_en = 1'b1;
    end else if (cls == u8d_pkg::ClsCont) begin
      partial_d = {partial_q[u8d_pkg::CpW-7:0], b[5:0]};
      taken_d   = taken_plus;
      if (complete) begin
        job.has_tail = 1'b1;
        job.tail_cp  = {partial_q[u8d_pkg::CpW-7:0], b[5:0]};
        job.tail_inv = 1'b0;
        job.tail_cnt = seq_len_q;
        partial_d    = '0;
        seq_len_d    = '0;
        taken_d      = '0;
      end
    end else begin
      // Break mid-sequence: drop the pending bytes, then decode this one afresh.
      job.inv_cnt = taken_q;
      partial_d   = '0;
      seq_len_d   = '0;
      taken_d     = '0;
      fresh_en    = 1'b1;
    end

    if (fresh_en) begin
      unique case (cls)
        u8d_pkg::ClsAscii: begin
          job.has_tail = 1'b1;
          job.tail_cp  = {{(u8d_pkg::CpW-8){1'b0}}, b};
          job.tail_inv = 1'b0;
          job.tail_cnt = u8d_pkg::CntW'(1);
        end
        u8d_pkg::ClsLead2: begin
          partial_d = {{(u8d_pkg::CpW-5){1'b0}}, b[4:0]};
          seq_len_d = u8d_pkg::CntW'(2);
          taken_d   = 2'd1;
        end
        u8d_pkg::ClsLead3: begin
          partial_d = {{(u8d_pkg::CpW-4){1'b0}}, b[3:0]};
          seq_len_d = u8d_pkg::CntW'(3);
          taken_d   = 2'd1;
        end
        u8d_pkg::ClsLead4: begin
          partial_d = {{(u8d_pkg::CpW-3){1'b0}}, b[2:0]};
          seq_len_d = u8d_pkg::CntW'(4);
          taken_d   = 2'd1;
        end
        default: begin
          job.has_tail = 1'b1;
          job.tail_cp  = '0;
          job.tail_inv = 1'b1;
          job.tail_cnt = u8d_pkg::CntW'(1);
        end
      endcase
    end
  end

  assign job_o  = job;
  assign push_o = accept && ((job.inv_cnt != 2'd0) || job.has_tail);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      seq_len_q <= '0;
      taken_q   <= '0;
    end else if (accept) begin
      partial_q <= partial_d;
      seq_len_q <= seq_len_d;
      taken_q   <= taken_d;
    end
  end

endmodule

// ===== rtl/u8d_queue.sv =====
// Short job queue between the front end and the result sequencer.
`timescale 1ns / 1ps

module u8d_queue #(
  parameter int unsigned DEPTH = u8d_pkg::QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  u8d_pkg::job_t      push_data_i,
  input  logic               pop_i,
  output u8d_pkg::job_t      pop_data_o,
  output u8d_pkg::q_status_t status_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  u8d_pkg::job_t       slots_q [DEPTH];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                do_push, do_pop;

  assign status_o.full      = (count_q == CntW'(DEPTH));
  assign status_o.not_empty = (count_q != '0);
  assign do_push            = push_i && !status_o.full;
  assign do_pop             = pop_i && status_o.not_empty;
  assign pop_data_o         = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/u8d_back.sv =====
// Back end: expands each job into results, one per cycle while the output is accepted.
`timescale 1ns / 1ps

module u8d_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  u8d_pkg::q_status_t q_status_i,
  input  u8d_pkg::job_t      q_data_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output u8d_pkg::out_t      out_data_o
);

  u8d_pkg::job_t job_q, job_d;
  logic          busy_q, busy_d;
  logic          out_accept;
  u8d_pkg::out_t res;

  always_comb begin
    res = '0;
    if (job_q.inv_cnt != 2'd0) begin
      res.code_point = '0;
      res.invalid    = 1'b1;
      res.byte_count = u8d_pkg::CntW'(1);
      res.last       = (job_q.inv_cnt == 2'd1) && !job_q.has_tail;
    end else begin
      res.code_point = job_q.tail_cp;
      res.invalid    = job_q.tail_inv;
      res.byte_count = job_q.tail_cnt;
      res.last       = 1'b1;
    end
  end

  assign out_valid_o = busy_q;
  assign out_data_o  = res;
  assign out_accept  = busy_q && out_ready_i;
  // Load the next job when idle or once the current one has delivered its last result.
  assign pop_o       = q_status_i.not_empty && (!busy_q || (out_accept && res.last));

  always_comb begin
    job_d  = job_q;
    busy_d = busy_q;
    if (!busy_q || (out_accept && res.last)) begin
      busy_d = q_status_i.not_empty;
      job_d  = q_data_i;
    end else if (out_accept) begin
      job_d.inv_cnt = job_q.inv_cnt - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

endmodule

// ===== rtl/utf8_stream_decoder.sv =====
// Top level of the UTF-8 stream decoder: front end, job queue and result sequencer.
//
//   channel  direction  handshake                payload
//   in       input      in_valid_i/in_ready_o    in_data_i  (kind, text_byte)
//   out      output     out_valid_o/out_ready_i  out_data_o (code_point, invalid,
//                                                            byte_count, last)
//
// One byte is taken per cycle while the job queue has room; the result
// sequencer gives one result per cycle while out_ready_i is high, and a
// request yields zero to four results; the queue absorbs the slack.
// A result is offered only after its job has been written into the queue
// and then loaded into the sequencer's job register.
// Reset clears the pending sequence, the queue and the output; no clearing pass.
// A stalled output fills the queue, then in_ready_o drops until it drains.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module utf8_stream_decoder #(
  parameter int unsigned QUEUE_DEPTH = u8d_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  u8d_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output u8d_pkg::out_t out_data_o
);

  u8d_pkg::q_status_t q_status;
  u8d_pkg::job_t      push_job;
  u8d_pkg::job_t      pop_job;
  logic               push;
  logic               pop;

  u8d_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_status_i (q_status),
    .push_o     (push),
    .job_o      (push_job)
  );

  u8d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .pop_i       (pop),
    .pop_data_o  (pop_job),
    .status_o    (q_status)
  );

  u8d_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .q_data_i    (pop_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  `ASSERT_ON(a_run_continues, clk_i, rst_ni,
             out_valid_o && out_ready_i && !out_data_o.last |=> out_valid_o)
  `ASSERT_ON(a_invalid_shape, clk_i, rst_ni,
             out_valid_o && out_data_o.invalid |->
             out_data_o.code_point == '0 && out_data_o.byte_count == 3'd1)
  `ASSERT_ON(a_single_ascii, clk_i, rst_ni,
             out_valid_o && !out_data_o.invalid && out_data_o.byte_count == 3'd1 |->
             out_data_o.code_point < 21'd128)
  `ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> !out_valid_o)

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the UTF-8 stream decoder: directed and random byte streams against a decode model.
`timescale 1ns / 1ps

module testbench;

  localparam int ResetCycles = 11;
  localparam int CycleLimit  = 20000;
  localparam int RandomItems = 100;
  localparam int IdlePercent = 36;
  localparam int HoldStart   = 60;
  localparam int HoldCycles  = 60;
  localparam int CalmFrom    = 200;
  localparam int CalmTo      = 320;
  localparam int DrainCycles = 10;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic          in_valid = 1'b0;
  logic          in_ready;
  u8d_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  u8d_pkg::out_t out_data;

  utf8_stream_decoder uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  int cycle = 0;
  int errors = 0;
  int hold_left = 0;
  logic calm;

  assign calm = (cycle >= CalmFrom) && (cycle < CalmTo);

  u8d_pkg::in_t  text_pending [$];
  u8d_pkg::out_t code_points_due [$];
  u8d_pkg::out_t want;

  // Decoder state as seen by the model.
  logic [20:0] seq_code = '0;
  logic [2:0]  seq_len = '0;
  logic [1:0]  seq_taken = '0;

  // Results of the request being decoded.
  u8d_pkg::out_t step_res [4];
  int step_cnt;

  task automatic add_result(input logic [20:0] cp, input logic inv, input logic [2:0] cnt);
    step_res[step_cnt] = '{code_point: cp, invalid: inv, byte_count: cnt, last: 1'b0};
    step_cnt++;
  endtask

  // One invalid result per byte of the open sequence, then drop it.
  task automatic flush_sequence();
    for (int i = 0; i < seq_taken && step_cnt < 4; i++) add_result('0, 1'b1, 3'd1);
    seq_code  = '0;
    seq_len   = '0;
    seq_taken = '0;
  endtask

  task automatic take_fresh(input logic [7:0] b);
    if (b[7] == 1'b0) begin
      add_result({13'd0, b}, 1'b0, 3'd1);
    end else if (b[7:5] == 3'b110) begin
      seq_code  = {16'd0, b[4:0]};
      seq_len   = 3'd2;
      seq_taken = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      seq_code  = {17'd0, b[3:0]};
      seq_len   = 3'd3;
      seq_taken = 2'd1;
    end else if (b[7:3] == 5'b11110) begin
      seq_code  = {18'd0, b[2:0]};
      seq_len   = 3'd4;
      seq_taken = 2'd1;
    end else begin
      add_result('0, 1'b1, 3'd1);
    end
  endtask

  task automatic decode_byte(input u8d_pkg::in_t req);
    logic [7:0] b;
    b = req.text_byte;
    step_cnt = 0;
    if (req.kind == u8d_pkg::KindEnd) begin
      flush_sequence();
    end else if (seq_len == 3'd0) begin
      take_fresh(b);
    end else if (b[7:6] == 2'b10) begin
      seq_code  = {seq_code[14:0], b[5:0]};
      seq_taken = seq_taken + 2'd1;
      // A four-byte form wraps the two-bit count back to zero when done.
      if ({1'b0, seq_taken} >= seq_len || seq_taken == 2'd0) begin
        add_result(seq_code, 1'b0, seq_len);
        seq_code  = '0;
        seq_len   = '0;
        seq_taken = '0;
      end
    end else begin
      flush_sequence();
      if (step_cnt < 4) take_fresh(b);
    end
    if (step_cnt > 0) step_res[step_cnt-1].last = 1'b1;
    for (int i = 0; i < step_cnt; i++) code_points_due.push_back(step_res[i]);
  endtask

  task automatic queue_byte(input logic [7:0] b);
    text_pending.push_back('{kind: u8d_pkg::KindByte, text_byte: b});
  endtask

  task automatic queue_end(input logic [7:0] b);
    text_pending.push_back('{kind: u8d_pkg::KindEnd, text_byte: b});
  endtask

  function automatic logic [7:0] lead_for(input int len);
    logic [7:0] r;
    r = 8'($urandom_range(255));
    case (len)
      1: r[7]   = 1'b0;
      2: r[7:5] = 3'b110;
      3: r[7:4] = 4'b1110;
      default: r[7:3] = 5'b11110;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] cont_byte();
    return {2'b10, 6'($urandom_range(63))};
  endfunction

  task automatic report_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (cycle >= CycleLimit) begin
      $display("%0t: timeout with %0d results still due", $time, code_points_due.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Driver: offer the next request unless idling.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else if (!in_valid || in_ready) begin
      if (text_pending.size() != 0 && (calm || $urandom_range(99) >= IdlePercent)) begin
        in_valid <= 1'b1;
        in_data  <= text_pending.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off to back up the input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (cycle == HoldStart) begin
      out_ready <= 1'b0;
      hold_left <= HoldCycles;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= IdlePercent);
    end
  end

  // Monitor: predict on each accepted request, check each accepted result.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) decode_byte(in_data);
      if (out_valid && out_ready) begin
        if (code_points_due.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %0h", $time, out_data);
          errors++;
        end else begin
          want = code_points_due.pop_front();
          report_field("code_point", 32'(want.code_point), 32'(out_data.code_point));
          report_field("invalid", 32'(want.invalid), 32'(out_data.invalid));
          report_field("byte_count", 32'(want.byte_count), 32'(out_data.byte_count));
          report_field("last", 32'(want.last), 32'(out_data.last));
        end
      end
    end
  end

  initial begin
    int added;
    int roll;
    int len;
    int conts;

    // Directed: ASCII extremes and full forms.
    queue_byte(8'h00);
    queue_byte(8'h7F);
    queue_byte(8'hC2); queue_byte(8'hA9);
    queue_byte(8'hE2); queue_byte(8'h82); queue_byte(8'hAC);
    queue_byte(8'hF7); queue_byte(8'hBF); queue_byte(8'hBF); queue_byte(8'hBF);
    // Stray continuation and bytes that can never lead.
    queue_byte(8'h80);
    queue_byte(8'hFF);
    queue_byte(8'hF8);
    // Break after three bytes, once by ASCII and once by a bad byte.
    queue_byte(8'hF0); queue_byte(8'h9F); queue_byte(8'h98); queue_byte(8'h41);
    queue_byte(8'hF0); queue_byte(8'h9F); queue_byte(8'h98); queue_byte(8'hF8);
    // End of text with a sequence open, then with none.
    queue_byte(8'hE2); queue_byte(8'h82); queue_end(8'hFF);
    queue_end(8'h00);

    added = 0;
    while (added < RandomItems) begin
      roll = $urandom_range(99);
      if (roll < 78) begin
        len = $urandom_range(1, 4);
        queue_byte(lead_for(len));
        for (int i = 1; i < len; i++) queue_byte(cont_byte());
        added += len;
      end else if (roll < 88) begin
        // Truncated form: the next item breaks it unless that item is a random continuation byte.
        len = $urandom_range(2, 4);
        conts = $urandom_range(0, len - 2);
        queue_byte(lead_for(len));
        for (int i = 0; i < conts; i++) queue_byte(cont_byte());
        added += conts + 1;
      end else if (roll < 94) begin
        queue_end(8'($urandom_range(255)));
        added++;
      end else begin
        queue_byte(8'($urandom_range(255)));
        added++;
      end
    end

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (text_pending.size() != 0 || in_valid) @(posedge clk_i);
    while (code_points_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/u8d_pkg.sv
rtl/u8d_front.sv
rtl/u8d_queue.sv
rtl/u8d_back.sv
rtl/utf8_stream_decoder.sv
dv/testbench.sv
